FILE: sv/stga_pkg.sv
// stga_pkg: widths, word types and register index codes for the strided
// tensor gather address unit. No dependencies.
`default_nettype none

package stga_pkg;

    localparam int NDIM      = 4;
    localparam int EXT_W     = 16;
    localparam int STR_W     = 24;
    localparam int IDX_W     = 32;
    localparam int OFS_W     = 42;
    localparam int PROD_W    = EXT_W + STR_W;
    localparam int CNT_W     = NDIM * EXT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = STR_W;

    typedef logic [EXT_W-1:0] ext_t;
    typedef logic [STR_W-1:0] stride_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [OFS_W-1:0] ofs_t;

    localparam ext_t    EXT_ONE  = ext_t'(1);
    localparam stride_t STR_ZERO = stride_t'(0);
    localparam stride_t STR_ONE  = stride_t'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM3 = 3'd7;

endpackage

`default_nettype wire

FILE: sv/stga_divider.sv
// stga_divider: pipelined restoring divider, one quotient bit per stage,
// 32-bit dividend by 16-bit divisor with a carried sideband. Uses stga_pkg.
`default_nettype none

module stga_divider
    import stga_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  wire              in_valid,
    input  wire idx_t        in_dividend,
    input  wire ext_t        divisor,
    input  wire [SIDE_W-1:0] in_side,
    output logic             out_valid,
    output idx_t             quotient,
    output ext_t             remainder,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [IDX_W];
    idx_t              num_reg   [IDX_W];
    ext_t              rem_reg   [IDX_W];
    logic [SIDE_W-1:0] side_reg  [IDX_W];

    genvar k;
    generate
        for (k = 0; k < IDX_W; k++) begin : g_stage
            logic              valid_in;
            idx_t              num_in;
            ext_t              rem_in;
            logic [SIDE_W-1:0] side_in;
            logic [EXT_W:0]    trial;
            logic [EXT_W:0]    diff;
            logic              fits;
            ext_t              rem_next;
            idx_t              num_next;

            if (k == 0) begin : g_first
                assign valid_in = in_valid;
                assign num_in   = in_dividend;
                assign rem_in   = '0;
                assign side_in  = in_side;
            end else begin : g_rest
                assign valid_in = valid_reg[k-1];
                assign num_in   = num_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign side_in  = side_reg[k-1];
            end

            // shift in next dividend bit, subtract when it fits
            assign trial    = {rem_in, num_in[IDX_W-1]};
            assign diff     = trial - {1'b0, divisor};
            assign fits     = (trial >= {1'b0, divisor});
            assign rem_next = fits ? diff[EXT_W-1:0] : trial[EXT_W-1:0];
            assign num_next = {num_in[IDX_W-2:0], fits};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[k]  <= num_next;
                    rem_reg[k]  <= rem_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[IDX_W-1];
    assign quotient  = num_reg[IDX_W-1];
    assign remainder = rem_reg[IDX_W-1];
    assign out_side  = side_reg[IDX_W-1];

endmodule

`default_nettype wire

FILE: sv/strided_tensor_gather_address_unit.sv
// Strided tensor gather address unit: top level with configuration registers,
// range check, three chained dividers and the offset multiply-add.
// Depends on stga_pkg and stga_divider.
//
// Usage:
//   s_ channel carries one linear element index per word; m_ channel returns
//   the strided source offset and an out-of-range flag, one word per input.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wr_data while
//   the unit holds no words; extents and strides take effect at once.
//   Pipeline: a word accepted on the s_ channel passes through four front
//   stages (the range check sits on the fourth), three 32-stage dividers at
//   one quotient bit per stage, then multiply, partial sum and final sum
//   stages before it appears on m_valid.
//   Throughput: one word per cycle while m_ready is high.
//   Stall: the whole pipeline holds while the output word waits; s_ready is
//   low exactly then, and nothing is lost or repeated.
//   Reset: aresetn low at a clock edge empties the pipeline and returns the
//   extents to 1, strides to 0 and the innermost stride to 1.
`default_nettype none

module strided_tensor_gather_address_unit
    import stga_pkg::*;
#(
    parameter int RANK = 4
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire idx_t             s_linear_index,
    output logic                  m_valid,
    input  wire                   m_ready,
    output ofs_t                  m_source_offset,
    output logic                  m_out_of_range,
    input  wire                   cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DAT_W-1:0]   cfg_wr_data
);

    localparam int FRONT = 4;

    ext_t    extent_reg [NDIM];
    stride_t stride_reg [NDIM];
    ext_t    ext_eff    [NDIM];

    logic [2*EXT_W-1:0] prod_hi_reg;
    logic [2*EXT_W-1:0] prod_lo_reg;
    logic [CNT_W-1:0]   count_reg;

    logic en;

    logic valid_f_reg [FRONT];
    idx_t idx_f_reg   [FRONT];
    logic oor_f3_reg;

    logic       d1_valid, d2_valid, d3_valid;
    idx_t       d1_q, d2_q, d3_q;
    ext_t       d1_r, d2_r, d3_r;
    logic [0:0] d1_side;
    logic [EXT_W:0]     d2_side;
    logic [2*EXT_W:0]   d3_side;

    logic              valid_m_reg;
    logic              oor_m_reg;
    logic [PROD_W-1:0] prod_reg [NDIM];

    logic              valid_s_reg;
    logic              oor_s_reg;
    logic [PROD_W:0]   sum01_reg;
    logic [PROD_W:0]   sum23_reg;

    logic              out_valid_reg;
    logic              out_oor_reg;
    ofs_t              out_ofs_reg;
    ofs_t              out_ofs_next;

    ext_t coord [NDIM];

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < NDIM; d++) begin
                extent_reg[d] <= EXT_ONE;
            end
            stride_reg[0] <= STR_ZERO;
            stride_reg[1] <= STR_ZERO;
            stride_reg[2] <= STR_ZERO;
            stride_reg[3] <= STR_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_EXTENT_DIM0: extent_reg[0] <= cfg_wr_data[EXT_W-1:0];
                REG_EXTENT_DIM1: extent_reg[1] <= cfg_wr_data[EXT_W-1:0];
                REG_EXTENT_DIM2: extent_reg[2] <= cfg_wr_data[EXT_W-1:0];
                REG_EXTENT_DIM3: extent_reg[3] <= cfg_wr_data[EXT_W-1:0];
                REG_STRIDE_DIM0: stride_reg[0] <= cfg_wr_data;
                REG_STRIDE_DIM1: stride_reg[1] <= cfg_wr_data;
                REG_STRIDE_DIM2: stride_reg[2] <= cfg_wr_data;
                REG_STRIDE_DIM3: stride_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // leading dimensions beyond the rank count as extent 1
    always_comb begin
        for (int d = 0; d < NDIM; d++) begin
            ext_eff[d] = (d >= NDIM - RANK) ? extent_reg[d] : EXT_ONE;
        end
    end

    // element count, refreshed every cycle from the extents
    always_ff @(posedge aclk) begin
        prod_hi_reg <= (2*EXT_W)'(ext_eff[0]) * (2*EXT_W)'(ext_eff[1]);
        prod_lo_reg <= (2*EXT_W)'(ext_eff[2]) * (2*EXT_W)'(ext_eff[3]);
        count_reg   <= CNT_W'(prod_hi_reg) * CNT_W'(prod_lo_reg);
    end

    // pipeline advances unless the output word is stalled
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // front stages carry the index until the count has settled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRONT; i++) begin
                valid_f_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_f_reg[0] <= s_valid;
            for (int i = 1; i < FRONT; i++) begin
                valid_f_reg[i] <= valid_f_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_f_reg[0] <= s_linear_index;
            for (int i = 1; i < FRONT; i++) begin
                idx_f_reg[i] <= idx_f_reg[i-1];
            end
            oor_f3_reg <= (CNT_W'(idx_f_reg[FRONT-2]) >= count_reg);
        end
    end

    // innermost coordinate
    stga_divider #(.SIDE_W(1)) u_div3 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (valid_f_reg[FRONT-1]),
        .in_dividend (idx_f_reg[FRONT-1]),
        .divisor     (ext_eff[3]),
        .in_side     (oor_f3_reg),
        .out_valid   (d1_valid),
        .quotient    (d1_q),
        .remainder   (d1_r),
        .out_side    (d1_side)
    );

    // third coordinate
    stga_divider #(.SIDE_W(EXT_W + 1)) u_div2 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (d1_valid),
        .in_dividend (d1_q),
        .divisor     (ext_eff[2]),
        .in_side     ({d1_side, d1_r}),
        .out_valid   (d2_valid),
        .quotient    (d2_q),
        .remainder   (d2_r),
        .out_side    (d2_side)
    );

    // second coordinate, quotient is the outermost one
    stga_divider #(.SIDE_W(2*EXT_W + 1)) u_div1 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (d2_valid),
        .in_dividend (d2_q),
        .divisor     (ext_eff[1]),
        .in_side     ({d2_side, d2_r}),
        .out_valid   (d3_valid),
        .quotient    (d3_q),
        .remainder   (d3_r),
        .out_side    (d3_side)
    );

    assign coord[3] = d3_side[2*EXT_W-1:EXT_W];
    assign coord[2] = d3_side[EXT_W-1:0];
    assign coord[1] = d3_r;
    assign coord[0] = d3_q[EXT_W-1:0];

    // coordinate times stride
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_m_reg <= 1'b0;
        end else if (en) begin
            valid_m_reg <= d3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oor_m_reg <= d3_side[2*EXT_W];
            for (int d = 0; d < NDIM; d++) begin
                prod_reg[d] <= PROD_W'(coord[d]) * PROD_W'(stride_reg[d]);
            end
        end
    end

    // partial sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_s_reg <= 1'b0;
        end else if (en) begin
            valid_s_reg <= valid_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oor_s_reg <= oor_m_reg;
            sum01_reg <= (PROD_W+1)'(prod_reg[0]) + (PROD_W+1)'(prod_reg[1]);
            sum23_reg <= (PROD_W+1)'(prod_reg[2]) + (PROD_W+1)'(prod_reg[3]);
        end
    end

    // final sum, zero when out of range
    assign out_ofs_next = oor_s_reg ? '0 : (OFS_W'(sum01_reg) + OFS_W'(sum23_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_s_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_oor_reg <= oor_s_reg;
            out_ofs_reg <= out_ofs_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_source_offset = out_ofs_reg;
    assign m_out_of_range  = out_oor_reg;

endmodule

`default_nettype wire
